// ----- rtl/core/bmp_cursor_pixel_to_bgra_assert.svh -----
// Assertion macros shared by the checker of the cursor pixel converter.
`ifndef BMP_CURSOR_PIXEL_TO_BGRA_ASSERT_SVH
`define BMP_CURSOR_PIXEL_TO_BGRA_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define BMPC_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bmpc assertion failed");

// Next-cycle implication, disabled while reset is high.
`define BMPC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bmpc assertion failed");

// Property that must hold in the cycle after reset is sampled high.
`define BMPC_ASSERT_AFTER_RESET(label, cons) \
   label: assert property (@(posedge clock) reset |=> (cons)) \
      else $error("bmpc reset assertion failed");

`endif

// ----- rtl/core/bmpc_pkg.sv -----
// Package with the constants, codes and types of the cursor pixel converter.
`timescale 1ns / 1ps
package bmpc_pkg;

   localparam int PALETTE_DEPTH = 256;
   localparam int PAL_AW        = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

   localparam int COUNT_W     = 9;
   localparam int DEPTH_W     = 3;
   localparam int COLOR_W     = 24;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 9;
   localparam int REQ_TDATA_W = 72;
   localparam int RSP_TDATA_W = 32;

   localparam logic [COUNT_W-1:0] PALETTE_LIMIT = COUNT_W'(PALETTE_DEPTH);

   localparam logic [DEPTH_W-1:0] DEPTH_1BPP  = 3'd0;
   localparam logic [DEPTH_W-1:0] DEPTH_4BPP  = 3'd1;
   localparam logic [DEPTH_W-1:0] DEPTH_8BPP  = 3'd2;
   localparam logic [DEPTH_W-1:0] DEPTH_24BPP = 3'd3;
   localparam logic [DEPTH_W-1:0] DEPTH_32BPP = 3'd4;

   localparam logic [COUNT_W-1:0] DEFAULT_COUNT_1BPP  = 9'd2;
   localparam logic [COUNT_W-1:0] DEFAULT_COUNT_4BPP  = 9'd16;
   localparam logic [COUNT_W-1:0] DEFAULT_COUNT_8BPP  = 9'd256;

   localparam logic [CSR_INDEX_W-1:0] CSR_DEPTH_MODE      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PALETTE_COUNT   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALPHA_FROM_DATA = 2'd2;

   localparam logic CMD_PALETTE_WRITE = 1'b0;
   localparam logic CMD_PIXEL         = 1'b1;

   localparam logic [7:0] ALPHA_OPAQUE      = 8'hFF;
   localparam logic [7:0] ALPHA_TRANSPARENT = 8'h00;

   typedef struct packed {
      logic [DEPTH_W-1:0] depth_mode;
      logic [COUNT_W-1:0] palette_count;
      logic               alpha_from_data;
   } bmpc_cfg_type;

   typedef struct packed {
      logic               is_indexed;
      logic               in_range;
      logic               unsupported;
      logic [7:0]         alpha;
      logic [COLOR_W-1:0] direct;
   } bmpc_stage_type;

endpackage

// ----- rtl/core/bmpc_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
module bmpc_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/bmpc_decode.sv -----
// Input stage: index extraction, palette range check, alpha and palette access.
`timescale 1ns / 1ps
module bmpc_decode import bmpc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  bmpc_cfg_type           cfg,
   input  logic                   take,
   input  logic                   req_cmd,
   input  logic [REQ_TDATA_W-1:0] req_data,
   input  logic                   pop,
   output logic                   stage_valid,
   output bmpc_stage_type         stage,
   output logic                   ram_rd_en,
   output logic [PAL_AW-1:0]      ram_rd_addr,
   output logic                   ram_wr_en,
   output logic [PAL_AW-1:0]      ram_wr_addr,
   output logic [COLOR_W-1:0]     ram_wr_data
);

   logic [7:0]         pal_index;
   logic [COLOR_W-1:0] pal_color;
   logic [31:0]        raw;
   logic [2:0]         column;
   logic               mask;
   logic [7:0]         byte0;
   logic [7:0]         idx;
   logic [COUNT_W-1:0] base_count;
   logic [COUNT_W-1:0] eff_count;
   logic               pixel_take;
   logic               stage_valid_ff;
   logic               stage_valid_in;
   bmpc_stage_type     stage_ff;
   bmpc_stage_type     stage_in;

   assign pal_index = req_data[7:0];
   assign pal_color = req_data[31:8];
   assign raw       = req_data[63:32];
   assign column    = req_data[66:64];
   assign mask      = req_data[67];
   assign byte0     = raw[7:0];

   always_comb begin
      unique case (cfg.depth_mode)
         DEPTH_1BPP: begin
            idx        = {7'd0, byte0[3'(3'd7 - column)]};
            base_count = DEFAULT_COUNT_1BPP;
         end
         DEPTH_4BPP: begin
            idx        = {4'd0, (column[0] ? byte0[3:0] : byte0[7:4])};
            base_count = DEFAULT_COUNT_4BPP;
         end
         default: begin
            idx        = byte0;
            base_count = DEFAULT_COUNT_8BPP;
         end
      endcase
      if (cfg.palette_count != '0) begin
         base_count = cfg.palette_count;
      end
      eff_count = (base_count > PALETTE_LIMIT) ? PALETTE_LIMIT : base_count;
   end

   always_comb begin
      stage_in             = '0;
      stage_in.is_indexed  = (cfg.depth_mode <= DEPTH_8BPP);
      stage_in.in_range    = ({1'b0, idx} < eff_count);
      stage_in.unsupported = (cfg.depth_mode > DEPTH_32BPP);
      stage_in.direct      = raw[23:0];
      if (stage_in.unsupported) begin
         stage_in.alpha = ALPHA_TRANSPARENT;
      end else if (cfg.depth_mode == DEPTH_32BPP && cfg.alpha_from_data) begin
         stage_in.alpha = raw[31:24];
      end else begin
         stage_in.alpha = mask ? ALPHA_TRANSPARENT : ALPHA_OPAQUE;
      end
   end

   assign pixel_take = take && (req_cmd == CMD_PIXEL);

   assign ram_rd_en   = pixel_take && stage_in.is_indexed && stage_in.in_range;
   assign ram_rd_addr = idx[PAL_AW-1:0];
   assign ram_wr_en   = take && (req_cmd == CMD_PALETTE_WRITE) &&
                        ({1'b0, pal_index} < PALETTE_LIMIT);
   assign ram_wr_addr = pal_index[PAL_AW-1:0];
   assign ram_wr_data = pal_color;

   always_comb begin
      if (pixel_take) begin
         stage_valid_in = 1'b1;
      end else if (pop) begin
         stage_valid_in = 1'b0;
      end else begin
         stage_valid_in = stage_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pixel_take) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_valid = stage_valid_ff;
   assign stage       = stage_ff;

endmodule

// ----- rtl/core/bmpc_format.sv -----
// Output stage: merges palette color or direct color with alpha into the result register.
`timescale 1ns / 1ps
module bmpc_format import bmpc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   stage_valid,
   input  bmpc_stage_type         stage,
   input  logic [COLOR_W-1:0]     ram_rd_data,
   output logic                   pop,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tuser
);

   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_in;
   logic                   rsp_unsup_ff;
   logic [COLOR_W-1:0]     color;

   assign pop = stage_valid && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      if (stage.unsupported) begin
         color = '0;
      end else if (stage.is_indexed) begin
         color = stage.in_range ? ram_rd_data : '0;
      end else begin
         color = stage.direct;
      end
      rsp_data_in = {stage.alpha, color};
   end

   always_comb begin
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_data_ff  <= rsp_data_in;
         rsp_unsup_ff <= stage.unsupported;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_unsup_ff;

endmodule

// ----- rtl/core/bmp_cursor_pixel_to_bgra.sv -----
// Top level of the cursor bitmap pixel to BGRA8888 converter.
// The block takes one transaction per clock unless a low rsp_tready stalls the output. One
// register stage holds the decoded pixel while the 256 x 24 palette RAM reads its registered
// port, and the result register follows. A palette write transaction (req_tuser low) stores
// its color at the rising edge that accepts it and gives no result; a pixel in the very next
// transaction already sees that color. Palette entries power up undefined and must be written
// before a pixel uses them. The user must write the registers (0 depth mode, 1 palette count,
// 2 alpha from data) via the csr port only while the block is idle, which it does not enforce.
`timescale 1ns / 1ps
module bmp_cursor_pixel_to_bgra import bmpc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // Bits from 0 up: palette_index, palette_color, pixel_raw, column_low, mask_bit, zero pad.
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // Bit 0: cmd.
   input  logic                   req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // Bits from 0 up: blue, green, red, alpha.
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // Bit 0: unsupported.
   output logic                   rsp_tuser,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   bmpc_cfg_type        cfg_ff;
   bmpc_cfg_type        cfg_in;
   logic                take;
   logic                pop;
   logic                stage_valid;
   bmpc_stage_type      stage;
   logic                ram_rd_en;
   logic [PAL_AW-1:0]   ram_rd_addr;
   logic [COLOR_W-1:0]  ram_rd_data;
   logic                ram_wr_en;
   logic [PAL_AW-1:0]   ram_wr_addr;
   logic [COLOR_W-1:0]  ram_wr_data;

   assign csr_ready = !reset;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_DEPTH_MODE:      cfg_in.depth_mode      = csr_wdata[DEPTH_W-1:0];
            CSR_PALETTE_COUNT:   cfg_in.palette_count   = csr_wdata[COUNT_W-1:0];
            CSR_ALPHA_FROM_DATA: cfg_in.alpha_from_data = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.depth_mode      <= DEPTH_8BPP;
         cfg_ff.palette_count   <= '0;
         cfg_ff.alpha_from_data <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_tready = !reset && (!stage_valid || pop);
   assign take       = req_tvalid && req_tready;

   bmpc_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .take        (take),
      .req_cmd     (req_tuser),
      .req_data    (req_tdata),
      .pop         (pop),
      .stage_valid (stage_valid),
      .stage       (stage),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data)
   );

   bmpc_ram #(
      .WIDTH (COLOR_W),
      .DEPTH (PALETTE_DEPTH)
   ) u_palette (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   bmpc_format u_format (
      .clock       (clock),
      .reset       (reset),
      .stage_valid (stage_valid),
      .stage       (stage),
      .ram_rd_data (ram_rd_data),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

endmodule

// ----- rtl/core/bmpc_checker.sv -----
// Port-level checker of the cursor pixel converter and its bind to the top level.
`timescale 1ns / 1ps
`include "bmp_cursor_pixel_to_bgra_assert.svh"
module bmpc_checker import bmpc_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   req_tuser,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic                   rsp_tuser
);

   logic pixel_take;

   assign pixel_take = req_tvalid && req_tready && (req_tuser == CMD_PIXEL);

   // A stalled result keeps its contents.
   `BMPC_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // An unsupported depth gives an all-zero pixel.
   `BMPC_ASSERT_NOW(a_unsup_black, rsp_tvalid && rsp_tuser, rsp_tdata == '0)

   // No result appears unless a pixel transaction was accepted in time to reach the output.
   `BMPC_ASSERT_NEXT(a_no_phantom, !rsp_tvalid && !$past(pixel_take), !rsp_tvalid)

   // Reset empties the result register.
   `BMPC_ASSERT_AFTER_RESET(a_reset_empty, !rsp_tvalid)

endmodule

bind bmp_cursor_pixel_to_bgra bmpc_checker u_checker (.*);
